FILE: src/psp_pkg.sv
package psp_pkg;

	// result kinds, carried on m_tuser
	localparam logic [1:0] KIND_PROGRAM = 2'd0;
	localparam logic [1:0] KIND_NETWORK = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;

	// section verdicts
	localparam logic [2:0] STAT_OK          = 3'd0;
	localparam logic [2:0] STAT_BAD_TABLE   = 3'd1;
	localparam logic [2:0] STAT_BAD_SYNTAX  = 3'd2;
	localparam logic [2:0] STAT_BAD_LENGTH  = 3'd3;
	localparam logic [2:0] STAT_CRC_ERROR   = 3'd4;
	localparam logic [2:0] STAT_NOT_CURRENT = 3'd5;

	localparam logic [7:0]  TABLE_ID_PAT   = 8'h00;
	localparam logic [7:0]  SYNTAX_MASK    = 8'h80;
	localparam logic [7:0]  VERSION_MASK   = 8'h3e;
	localparam logic [7:0]  CURRENT_MASK   = 8'h01;
	localparam logic [7:0]  PID_HIGH_MASK  = 8'h1f;
	localparam logic [11:0] MIN_SECTION_LENGTH = 12'd9;
	localparam logic [31:0] CRC_POLY = 32'h04c11db7;
	localparam logic [31:0] CRC_INIT = 32'hffffffff;

	localparam int DATA_WIDTH = 88;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROC,
		S_SEARCH,
		S_DECIDE
	} fsm_state_t;

	typedef struct packed {
		logic capture;
		logic commit;
		logic search;
		logic decide;
	} psp_cmd_t;

	typedef struct packed {
		logic p_emit;
		logic p_search;
		logic out_free;
		logic search_done;
		logic is_dup;
	} psp_sts_t;

	// msb-first crc over one byte
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'h000000};
		for (int i = 0; i < 8; i++) begin
			c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
		end
		return c;
	endfunction

endpackage

FILE: src/pat_section_parser.sv
// Parses one MPEG-2 program association section, one byte per input transaction,
// s_tuser marking the table id byte. Each byte is first captured, then applied to
// the header/CRC state; on the fourth byte of a program entry with a nonzero
// program number in a current section the PID is compared against the PIDs already
// stored for this section, one table read per cycle (search, then keep or drop).
// Entries are delivered before the CRC is known: a section's entries are only
// trustworthy if its closing status transaction reports ok. A new transaction is
// taken while a result waits in the output register; the byte is held until that
// register frees when it produces a result of its own.
module pat_section_parser #(
	parameter int DUP_TABLE_DEPTH    = 64,
	parameter int MAX_SECTION_LENGTH = 1021
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // data_byte
	input  logic                           s_tuser,  // section_start
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// prog_num, pid, ts_id, version, section_index,
	// last_section_index, status, section_bytes, dup_table_full, zero fill
	output logic [psp_pkg::DATA_WIDTH-1:0] m_tdata,
	output logic [1:0]                     m_tuser   // result_kind
);
	import psp_pkg::*;

	psp_cmd_t cmd;
	psp_sts_t sts;

	psp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	psp_datapath #(
		.DUP_TABLE_DEPTH    (DUP_TABLE_DEPTH),
		.MAX_SECTION_LENGTH (MAX_SECTION_LENGTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: src/psp_ctrl.sv
module psp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  psp_pkg::psp_sts_t sts,
	output psp_pkg::psp_cmd_t cmd
);
	import psp_pkg::*;

	fsm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_PROC;
				end
			end
			S_PROC: begin
				// hold the byte until the output register can take its result
				if (!sts.p_emit || sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = sts.p_search ? S_SEARCH : S_IDLE;
				end
			end
			S_SEARCH: begin
				cmd.search = 1'b1;
				if (sts.search_done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.is_dup || sts.out_free) begin
					cmd.decide = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: src/psp_datapath.sv
module psp_datapath #(
	parameter int DUP_TABLE_DEPTH    = 64,
	parameter int MAX_SECTION_LENGTH = 1021
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [7:0]                        s_tdata,
	input  logic                              s_tuser,
	input  psp_pkg::psp_cmd_t                 cmd,
	output psp_pkg::psp_sts_t                 sts,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [psp_pkg::DATA_WIDTH-1:0]    m_tdata,
	output logic [1:0]                        m_tuser
);
	import psp_pkg::*;

	localparam int CW = $clog2(DUP_TABLE_DEPTH + 1);
	localparam int AW = (DUP_TABLE_DEPTH > 1) ? $clog2(DUP_TABLE_DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(DUP_TABLE_DEPTH);
	localparam logic [11:0]   MAX_LEN = 12'(MAX_SECTION_LENGTH);

	// captured input transaction
	logic [7:0]  byte_q;
	logic        start_q;

	// section state
	logic        active_q;
	logic [9:0]  pos_q;
	logic [9:0]  len_q;
	logic [23:0] asm_q;
	logic [31:0] crc_q;
	logic [15:0] tsid_q;
	logic [4:0]  ver_q;
	logic [7:0]  sec_q;
	logic [7:0]  last_q;
	logic        nc_q;
	logic [CW-1:0] cnt_q;
	logic        full_q;

	// pending program entry and pid search
	logic [15:0] prog_q;
	logic [12:0] pid_q;
	logic [CW-1:0] sidx_q;
	logic [12:0] rd_q;
	logic        rdv_q;
	logic        match_q;
	logic [12:0] mem [DUP_TABLE_DEPTH];

	// output register
	logic        out_valid_q;
	logic [1:0]  o_kind_q;
	logic [15:0] o_prog_q;
	logic [12:0] o_pid_q;
	logic [15:0] o_tsid_q;
	logic [4:0]  o_ver_q;
	logic [7:0]  o_sec_q;
	logic [7:0]  o_last_q;
	logic [2:0]  o_stat_q;
	logic [10:0] o_nb_q;
	logic        o_full_q;

	// byte processing
	logic [9:0]  pos_inc, k, rest;
	logic [31:0] crc_calc;
	logic [11:0] len_raw;
	logic [10:0] nbytes;
	logic        act_nx;
	logic [9:0]  pos_nx, len_nx;
	logic [23:0] asm_nx;
	logic [31:0] crc_nx;
	logic [15:0] tsid_nx;
	logic [4:0]  ver_nx;
	logic [7:0]  sec_nx, last_nx;
	logic        nc_nx;
	logic        p_emit, p_search, p_hdr;
	logic [1:0]  p_kind;
	logic [2:0]  p_stat;
	logic [10:0] p_nb;
	logic [12:0] p_pid;
	logic [15:0] p_prog;
	logic        out_free, load_proc, load_dec, table_full;

	assign out_free   = !out_valid_q || m_tready;
	assign table_full = (cnt_q == DEPTH_C);
	assign load_proc  = cmd.commit && p_emit;
	assign load_dec   = cmd.decide && !match_q;

	always_comb begin
		pos_inc  = pos_q + 10'd1;
		crc_calc = crc32_byte(start_q ? CRC_INIT : crc_q, byte_q);
		len_raw  = {asm_q[3:0], byte_q};
		k        = pos_inc - 10'd8;
		rest     = len_q - 10'd9;
		nbytes   = {1'b0, len_q} + 11'd3;

		act_nx   = active_q;
		pos_nx   = pos_q;
		len_nx   = len_q;
		asm_nx   = asm_q;
		crc_nx   = crc_q;
		tsid_nx  = tsid_q;
		ver_nx   = ver_q;
		sec_nx   = sec_q;
		last_nx  = last_q;
		nc_nx    = nc_q;
		p_emit   = 1'b0;
		p_search = 1'b0;
		p_hdr    = 1'b1;
		p_kind   = KIND_STATUS;
		p_stat   = STAT_OK;
		p_nb     = nbytes;
		p_pid    = {asm_q[4:0], byte_q};
		p_prog   = asm_q[23:8];

		if (start_q) begin
			// a start abandons whatever section was in progress
			act_nx  = (byte_q == TABLE_ID_PAT);
			pos_nx  = '0;
			len_nx  = '0;
			asm_nx  = '0;
			crc_nx  = crc_calc;
			tsid_nx = '0;
			ver_nx  = '0;
			sec_nx  = '0;
			last_nx = '0;
			nc_nx   = 1'b0;
			if (byte_q != TABLE_ID_PAT) begin
				p_emit = 1'b1;
				p_stat = STAT_BAD_TABLE;
				p_hdr  = 1'b0;
				p_nb   = '0;
			end
		end else if (active_q) begin
			pos_nx = pos_inc;
			crc_nx = crc_calc;
			case (pos_inc)
				10'd1: begin
					if ((byte_q & SYNTAX_MASK) == 8'h00) begin
						act_nx = 1'b0;
						p_emit = 1'b1;
						p_stat = STAT_BAD_SYNTAX;
						p_hdr  = 1'b0;
						p_nb   = '0;
					end else begin
						asm_nx = {20'h00000, byte_q[3:0]};
					end
				end
				10'd2: begin
					asm_nx = '0;
					if (len_raw < MIN_SECTION_LENGTH || len_raw > MAX_LEN) begin
						act_nx = 1'b0;
						p_emit = 1'b1;
						p_stat = STAT_BAD_LENGTH;
						p_hdr  = 1'b0;
						p_nb   = '0;
					end else begin
						len_nx = len_raw[9:0];
					end
				end
				10'd3: tsid_nx = {byte_q, 8'h00};
				10'd4: tsid_nx = {tsid_q[15:8], byte_q};
				10'd5: begin
					ver_nx = 5'((byte_q & VERSION_MASK) >> 1);
					nc_nx  = ((byte_q & CURRENT_MASK) == 8'h00);
				end
				10'd6: sec_nx = byte_q;
				10'd7: last_nx = byte_q;
				default: begin
					if ({1'b0, pos_inc} >= {1'b0, len_q} + 11'd2) begin
						act_nx = 1'b0;
						p_emit = 1'b1;
						if (crc_calc != 32'h0) begin
							p_stat = STAT_CRC_ERROR;
						end else if (nc_q) begin
							p_stat = STAT_NOT_CURRENT;
						end else begin
							p_stat = STAT_OK;
						end
					end else if (k < {rest[9:2], 2'b00}) begin
						if (k[1:0] != 2'd3) begin
							asm_nx = {asm_q[15:0], byte_q};
						end else begin
							asm_nx = '0;
							p_pid  = {asm_q[4:0] & PID_HIGH_MASK[4:0], byte_q};
							if (!nc_q) begin
								if (asm_q[23:8] == 16'h0000) begin
									p_emit = 1'b1;
									p_kind = KIND_NETWORK;
								end else begin
									p_search = 1'b1;
								end
							end
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q  <= s_tdata;
			start_q <= s_tuser;
		end
		if (cmd.commit && p_search) begin
			prog_q <= p_prog;
			pid_q  <= p_pid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= '0;
			len_q    <= '0;
			asm_q    <= '0;
			crc_q    <= CRC_INIT;
			tsid_q   <= '0;
			ver_q    <= '0;
			sec_q    <= '0;
			last_q   <= '0;
			nc_q     <= 1'b0;
			cnt_q    <= '0;
			full_q   <= 1'b0;
		end else begin
			if (cmd.commit) begin
				active_q <= act_nx;
				pos_q    <= pos_nx;
				len_q    <= len_nx;
				asm_q    <= asm_nx;
				crc_q    <= crc_nx;
				tsid_q   <= tsid_nx;
				ver_q    <= ver_nx;
				sec_q    <= sec_nx;
				last_q   <= last_nx;
				nc_q     <= nc_nx;
				if (start_q) begin
					cnt_q  <= '0;
					full_q <= 1'b0;
				end
			end else if (load_dec) begin
				if (table_full) begin
					full_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// pid table, one read per cycle during the search
	always_ff @(posedge clk) begin
		if (load_dec && !table_full) begin
			mem[cnt_q[AW-1:0]] <= pid_q;
		end
		if (cmd.search && (sidx_q < cnt_q)) begin
			rd_q <= mem[sidx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sidx_q  <= '0;
			rdv_q   <= 1'b0;
			match_q <= 1'b0;
		end else if (cmd.commit && p_search) begin
			sidx_q  <= '0;
			rdv_q   <= 1'b0;
			match_q <= 1'b0;
		end else if (cmd.search) begin
			if (sidx_q < cnt_q) begin
				sidx_q <= sidx_q + 1'b1;
				rdv_q  <= 1'b1;
			end else begin
				rdv_q <= 1'b0;
			end
			if (rdv_q && (rd_q == pid_q)) begin
				match_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_proc || load_dec) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_proc) begin
			o_kind_q <= p_kind;
			o_prog_q <= '0;
			o_pid_q  <= (p_kind == KIND_NETWORK) ? p_pid : 13'h0000;
			o_tsid_q <= p_hdr ? tsid_q : 16'h0000;
			o_ver_q  <= p_hdr ? ver_q : 5'h00;
			o_sec_q  <= p_hdr ? sec_q : 8'h00;
			o_last_q <= p_hdr ? last_q : 8'h00;
			o_stat_q <= p_stat;
			o_nb_q   <= p_nb;
			o_full_q <= p_hdr ? full_q : 1'b0;
		end else if (load_dec) begin
			o_kind_q <= KIND_PROGRAM;
			o_prog_q <= prog_q;
			o_pid_q  <= pid_q;
			o_tsid_q <= tsid_q;
			o_ver_q  <= ver_q;
			o_sec_q  <= sec_q;
			o_last_q <= last_q;
			o_stat_q <= STAT_OK;
			o_nb_q   <= nbytes;
			o_full_q <= full_q | table_full;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = o_kind_q;
	assign m_tdata  = {7'h00, o_full_q, o_nb_q, o_stat_q, o_last_q, o_sec_q,
			o_ver_q, o_tsid_q, o_pid_q, o_prog_q};

	assign sts.p_emit      = p_emit;
	assign sts.p_search    = p_search;
	assign sts.out_free    = out_free;
	assign sts.search_done = (sidx_q >= cnt_q) && !rdv_q;
	assign sts.is_dup      = match_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("pid table count beyond depth");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> table_full)
		else $error("overflow flag set with room in the table");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(load_proc || load_dec) |-> out_free)
		else $error("output register overwritten before it was taken");

	a_search_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && p_search) |=> (sidx_q == '0 && !match_q && !rdv_q))
		else $error("pid search did not start from the first entry");

	a_dup_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |-> (sidx_q >= cnt_q && !rdv_q))
		else $error("entry decided before the pid search finished");

endmodule

FILE: dv/tb_pat_section_parser.sv
`timescale 1ns / 100ps

module tb_pat_section_parser;
	import psp_pkg::*;

	localparam int DUP_DEPTH   = 64;
	localparam int MAX_LEN     = 1021;
	localparam int CYCLE_LIMIT = 1000000;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		logic [15:0] prog;
		logic [12:0] pid;
	} pat_entry_t;

	typedef pat_entry_t entry_q_t[$];

	typedef struct {
		logic [1:0]  kind;
		logic [15:0] prog;
		logic [12:0] pid;
		logic [15:0] tsid;
		logic [4:0]  ver;
		logic [7:0]  sec_idx;
		logic [7:0]  last_idx;
		logic [2:0]  stat;
		logic [10:0] nbytes;
		logic        overflow;
	} pat_result_t;

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata  = 8'h00;
	logic                  s_tuser  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [DATA_WIDTH-1:0] m_tdata;
	logic [1:0]            m_tuser;

	pat_section_parser #(
		.DUP_TABLE_DEPTH(DUP_DEPTH),
		.MAX_SECTION_LENGTH(MAX_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// parser state as tracked by the testbench
	bit          in_section;
	logic [9:0]  sec_pos;
	int          sec_len;
	logic [23:0] entry_acc;
	logic [31:0] sec_crc;
	logic [15:0] hdr_tsid;
	logic [4:0]  hdr_ver;
	logic [7:0]  hdr_sec;
	logic [7:0]  hdr_last;
	bit          not_current;
	logic [12:0] seen_pid[DUP_DEPTH];
	int          seen_count;
	bit          table_overflow;

	pat_result_t pat_results_due[$];
	int          parsed_bytes;
	int          errors;
	int          cycle_count;
	int          burst_left;

	// msb-first, one message bit at a time
	function automatic logic [31:0] mpeg_crc_update(logic [31:0] c, logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[31] ^ b[i];
			c = {c[30:0], 1'b0};
			if (fb) c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	function automatic void push_result(logic [1:0] kind, logic [15:0] prog, logic [12:0] pid,
			logic [2:0] stat, int nbytes, bit with_hdr);
		pat_result_t r;
		r.kind     = kind;
		r.prog     = prog;
		r.pid      = pid;
		r.tsid     = with_hdr ? hdr_tsid : '0;
		r.ver      = with_hdr ? hdr_ver : '0;
		r.sec_idx  = with_hdr ? hdr_sec : '0;
		r.last_idx = with_hdr ? hdr_last : '0;
		r.stat     = stat;
		r.nbytes   = 11'(nbytes);
		r.overflow = table_overflow;
		pat_results_due = {pat_results_due, r};
	endfunction

	function automatic void parse_pat_byte(logic [7:0] b, logic st);
		int          k;
		int          rest;
		int          span;
		logic [15:0] prog;
		logic [12:0] pid;
		bit          dup;
		if (st) begin
			in_section     = 1'b0;
			sec_pos        = '0;
			sec_len        = 0;
			entry_acc      = '0;
			hdr_tsid       = '0;
			hdr_ver        = '0;
			hdr_sec        = '0;
			hdr_last       = '0;
			not_current    = 1'b0;
			seen_count     = 0;
			table_overflow = 1'b0;
			sec_crc        = mpeg_crc_update(CRC_INIT, b);
			parsed_bytes++;
			if (b != TABLE_ID_PAT) push_result(KIND_STATUS, 0, 0, STAT_BAD_TABLE, 0, 1'b0);
			else in_section = 1'b1;
			return;
		end
		if (!in_section) return;
		parsed_bytes++;
		sec_pos = sec_pos + 10'd1;
		sec_crc = mpeg_crc_update(sec_crc, b);

		if (sec_pos <= 10'd7) begin
			case (sec_pos)
				10'd1: begin
					if ((b & SYNTAX_MASK) == 8'h00) begin
						in_section = 1'b0;
						push_result(KIND_STATUS, 0, 0, STAT_BAD_SYNTAX, 0, 1'b0);
					end else begin
						entry_acc = {20'h0, b[3:0]};
					end
				end
				10'd2: begin
					span = {entry_acc[3:0], b};
					entry_acc = '0;
					if (span < MIN_SECTION_LENGTH || span > MAX_LEN) begin
						in_section = 1'b0;
						push_result(KIND_STATUS, 0, 0, STAT_BAD_LENGTH, 0, 1'b0);
					end else begin
						sec_len = span;
					end
				end
				10'd3: hdr_tsid = {b, 8'h00};
				10'd4: hdr_tsid[7:0] = b;
				10'd5: begin
					hdr_ver     = 5'((b & VERSION_MASK) >> 1);
					not_current = (b & CURRENT_MASK) == 8'h00;
				end
				10'd6: hdr_sec = b;
				default: hdr_last = b;
			endcase
			return;
		end

		if (sec_pos >= 2 + sec_len) begin
			in_section = 1'b0;
			push_result(KIND_STATUS, 0, 0,
				(sec_crc != 0) ? STAT_CRC_ERROR : (not_current ? STAT_NOT_CURRENT : STAT_OK),
				3 + sec_len, 1'b1);
			return;
		end

		// program loop: whole 4-byte entries only, trailing odd bytes skipped
		k = sec_pos - 8;
		rest = sec_len - 9;
		if (k >= (rest & ~3)) return;
		if (k % 4 != 3) begin
			entry_acc = {entry_acc[15:0], b};
			return;
		end
		prog = entry_acc[23:8];
		pid = {entry_acc[4:0], b};
		entry_acc = '0;
		if (not_current) return;
		if (prog == 16'h0000) begin
			push_result(KIND_NETWORK, 0, pid, STAT_OK, 3 + sec_len, 1'b1);
			return;
		end
		dup = 1'b0;
		for (int i = 0; i < seen_count; i++) begin
			if (seen_pid[i] == pid) dup = 1'b1;
		end
		if (dup) return;
		if (seen_count < DUP_DEPTH) begin
			seen_pid[seen_count] = pid;
			seen_count++;
		end else begin
			table_overflow = 1'b1;
		end
		push_result(KIND_PROGRAM, prog, pid, STAT_OK, 3 + sec_len, 1'b1);
	endfunction

	function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// result checker
	always @(posedge clk) begin
		pat_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pat_results_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual kind %0d data %h",
					$time, m_tuser, m_tdata);
			end else begin
				want = pat_results_due.pop_front();
				errors += field_diff("result_kind", want.kind, m_tuser)
					+ field_diff("prog_num", want.prog, m_tdata[15:0])
					+ field_diff("pid", want.pid, m_tdata[28:16])
					+ field_diff("ts_id", want.tsid, m_tdata[44:29])
					+ field_diff("version", want.ver, m_tdata[49:45])
					+ field_diff("section_index", want.sec_idx, m_tdata[57:50])
					+ field_diff("last_section_index", want.last_idx, m_tdata[65:58])
					+ field_diff("status", want.stat, m_tdata[68:66])
					+ field_diff("section_bytes", want.nbytes, m_tdata[79:69])
					+ field_diff("dup_table_full", want.overflow, m_tdata[80])
					+ field_diff("zero fill", 0, m_tdata[87:81]);
			end
		end
	end

	// receiver back-pressure, reloaded now and then
	logic [15:0] rx_pattern = 16'hffff;
	logic [3:0]  rx_phase   = 4'd0;
	int          rx_hold    = 0;

	always @(posedge clk) begin
		rx_phase <= rx_phase + 4'd1;
		m_tready <= rx_pattern[rx_phase];
		if (rx_hold == 0) begin
			rx_hold <= $urandom_range(40, 400);
			case ($urandom_range(0, 3))
				0: rx_pattern <= 16'hffff;
				1: rx_pattern <= 16'h0001;
				default: rx_pattern <= 16'($urandom) | 16'h0001;
			endcase
		end else begin
			rx_hold <= rx_hold - 1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// valid is left high after a transaction, the next call or a drain decides
	task automatic send_byte(logic [7:0] b, logic st);
		int gap_len;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap_len > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap_len) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= st;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		parse_pat_byte(b, st);
	endtask

	task automatic send_bytes(ref byte_q_t q, input int count);
		for (int i = 0; i < count; i++) send_byte(q[i], i == 0);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pat_results_due.size() != 0) @(posedge clk);
		repeat (DUP_DEPTH + 8) @(posedge clk);
	endtask

	task automatic build_section(ref byte_q_t q, input logic [15:0] tsid, input logic [4:0] ver,
			input bit current, input logic [7:0] sec, input logic [7:0] last,
			ref entry_q_t ents, input int partial, input bit bad_crc);
		logic [11:0] len;
		logic [31:0] crc;
		len = 12'(9 + 4 * ents.size() + partial);
		q = {};
		q = {q, TABLE_ID_PAT};
		q = {q, SYNTAX_MASK | 8'($urandom_range(0, 7) << 4) | {4'h0, len[11:8]}};
		q = {q, len[7:0]};
		q = {q, tsid[15:8]};
		q = {q, tsid[7:0]};
		q = {q, {2'($urandom), ver, current}};
		q = {q, sec};
		q = {q, last};
		foreach (ents[i]) begin
			q = {q, ents[i].prog[15:8]};
			q = {q, ents[i].prog[7:0]};
			q = {q, {3'($urandom), ents[i].pid[12:8]}};
			q = {q, ents[i].pid[7:0]};
		end
		repeat (partial) q = {q, 8'($urandom)};
		crc = CRC_INIT;
		foreach (q[i]) crc = mpeg_crc_update(crc, q[i]);
		q = {q, crc[31:24]};
		q = {q, crc[23:16]};
		q = {q, crc[15:8]};
		q = {q, crc[7:0] ^ (bad_crc ? 8'($urandom_range(1, 255)) : 8'h00)};
	endtask

	// a few pids are reused so that duplicates turn up
	task automatic fill_entries(ref entry_q_t ents, input int n);
		logic [12:0] pool[8];
		pat_entry_t  e;
		foreach (pool[i]) pool[i] = 13'($urandom);
		ents = {};
		repeat (n) begin
			e.pid  = ($urandom_range(0, 9) < 4) ? pool[$urandom_range(0, 7)] : 13'($urandom);
			e.prog = ($urandom_range(0, 6) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
			ents = {ents, e};
		end
	endtask

	task automatic test_header_faults();
		send_byte(8'hff, 1'b0);            // no section open, ignored
		send_byte(8'hff, 1'b1);            // wrong table id
		send_byte(TABLE_ID_PAT, 1'b1);
		send_byte(8'h7f, 1'b0);            // syntax bit clear
		send_byte(TABLE_ID_PAT, 1'b1);
		send_byte(8'hf0, 1'b0);
		send_byte(8'h08, 1'b0);            // length one short of the minimum
		send_byte(TABLE_ID_PAT, 1'b1);
		send_byte(8'hb3, 1'b0);
		send_byte(8'hfe, 1'b0);            // length one above the maximum
	endtask

	task automatic test_entry_rules();
		byte_q_t    q;
		entry_q_t   ents;
		pat_entry_t e;
		// header begun then abandoned by the next start
		send_byte(TABLE_ID_PAT, 1'b1);
		send_byte(8'hb0, 1'b0);
		send_byte(8'h0d, 1'b0);
		ents = {};
		e.prog = 16'h0000; e.pid = 13'h1fff; ents = {ents, e};
		e.prog = 16'hffff; e.pid = 13'h0000; ents = {ents, e};
		e.prog = 16'h0001; e.pid = 13'h0000; ents = {ents, e};   // repeated pid, dropped
		build_section(q, 16'hffff, 5'h1f, 1'b1, 8'hff, 8'hff, ents, 1, 1'b0);
		send_bytes(q, q.size());
	endtask

	task automatic test_longest_section();
		byte_q_t  q;
		entry_q_t ents;
		fill_entries(ents, (MAX_LEN - 9) / 4);
		build_section(q, 16'h0000, 5'h00, 1'b1, 8'h00, 8'h00, ents, 0, 1'b0);
		send_bytes(q, q.size());
	endtask

	task automatic test_random_sections();
		byte_q_t     q;
		entry_q_t    ents;
		int          goal;
		int          pick;
		int          sections;
		int          n;
		logic [11:0] len;
		goal = 1700;
		sections = 0;
		while (parsed_bytes < goal) begin
			sections++;
			if (sections % 40 == 0) wait_drained();
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				send_byte(8'($urandom_range(1, 255)), 1'b1);
			end else if (pick < 6) begin
				send_byte(TABLE_ID_PAT, 1'b1);
				send_byte(8'($urandom_range(0, 127)), 1'b0);
			end else if (pick < 9) begin
				len = $urandom_range(0, 1) ? 12'($urandom_range(0, 8))
					: 12'($urandom_range(MAX_LEN + 1, 4095));
				send_byte(TABLE_ID_PAT, 1'b1);
				send_byte(SYNTAX_MASK | 8'($urandom_range(0, 7) << 4) | {4'h0, len[11:8]}, 1'b0);
				send_byte(len[7:0], 1'b0);
			end else if (pick < 15) begin
				// loose bytes, now and then with a start
				repeat ($urandom_range(1, 8)) begin
					if ($urandom_range(0, 7) == 0)
						send_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom), 1'b1);
					else
						send_byte(8'($urandom), 1'b0);
				end
			end else begin
				n = (pick < 18) ? $urandom_range(DUP_DEPTH + 1, DUP_DEPTH + 8)
					: $urandom_range(0, 12);
				fill_entries(ents, n);
				build_section(q, 16'($urandom), 5'($urandom), $urandom_range(0, 6) != 0,
					8'($urandom), 8'($urandom), ents,
					($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
					$urandom_range(0, 9) == 0);
				// some sections are cut short and abandoned by the next start
				send_bytes(q, (pick < 28) ? $urandom_range(1, q.size() - 1) : q.size());
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_faults();
		test_entry_rules();
		wait_drained();
		test_longest_section();
		wait_drained();
		test_random_sections();
		wait_drained();
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: files.f
src/psp_pkg.sv
src/psp_ctrl.sv
src/psp_datapath.sv
src/pat_section_parser.sv
dv/tb_pat_section_parser.sv
